// ===== design/sbr_pkg.sv =====
// Shared widths and types of the stream byte reassembler.
package sbr_pkg;

    localparam int unsigned INDEX_W = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ROOM_W  = 7;
    localparam int unsigned COUNT_W = 7;

    // One store entry: present mark and byte value share a word.
    typedef struct packed {
        logic              present;
        logic [BYTE_W-1:0] data;
    } t_entry;

endpackage

// ===== design/sbr_if.sv =====
// Item channels of the stream byte reassembler: input segment bytes and released bytes.
interface sbr_in_if;
    logic                            valid;
    logic                            ready;
    logic [sbr_pkg::INDEX_W-1:0]     stream_index;
    logic [sbr_pkg::BYTE_W-1:0]      data_byte;
    logic                            has_byte;
    logic                            ends_stream;
    logic [sbr_pkg::ROOM_W-1:0]      output_room;

    modport source (output valid, stream_index, data_byte, has_byte, ends_stream,
                    output_room, input ready);
    modport sink   (input valid, stream_index, data_byte, has_byte, ends_stream,
                    output_room, output ready);
endinterface

interface sbr_out_if;
    logic                            valid;
    logic                            ready;
    logic [sbr_pkg::BYTE_W-1:0]      out_byte;
    logic                            byte_valid;
    logic                            last_of_run;
    logic                            stream_closed;
    logic [sbr_pkg::COUNT_W-1:0]     pending_count;

    modport source (output valid, out_byte, byte_valid, last_of_run, stream_closed,
                    pending_count, input ready);
    modport sink   (input valid, out_byte, byte_valid, last_of_run, stream_closed,
                    pending_count, output ready);
endinterface

// ===== design/sbr_store.sv =====
// Single-port byte store with present marks, registered read data.
module sbr_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic                i_re,
    input  logic [AW-1:0]       i_addr,
    input  sbr_pkg::t_entry     i_wdata,
    output sbr_pkg::t_entry     o_rdata
);

    sbr_pkg::t_entry r_mem [DEPTH];
    sbr_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/stream_byte_reassembler.sv =====
// Stream byte reassembler: reorders indexed stream bytes and releases them in order.
//
// Usage:
//   i_in  carries one item per byte: absolute stream_index, data_byte, has_byte,
//         ends_stream and the free output_room downstream. Bytes inside the window
//         [released, released + min(room, WINDOW_BYTES)) are stored, others dropped.
//   o_out carries the results of an item: one per released byte in stream order,
//         or a single status item when nothing is released. last_of_run marks the
//         final result of an item; stream_closed and pending_count are the values
//         after the whole item.
// Steps (one single-port store, so each store access is a read or a write):
//   take the item, check the window, then read the old entry and write the byte
//   (both skipped when the byte is dropped); read slot by slot to measure the
//   in-order run and the slot that ends it (none when the run fills the window);
//   settle, then read, send and clear each released byte or send a status result, held by any output stall.
// Reset:
//   i_rst_n is synchronous, active low. After reset a clearing pass writes every
//   store entry, with i_in.ready low.
// Stall:
//   A result waits in the output register; a stalled receiver holds the release
//   loop, and the next item can be accepted while the last result still waits.
module stream_byte_reassembler #(
    parameter int unsigned WINDOW_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbr_in_if.sink      i_in,
    sbr_out_if.source   o_out
);

    localparam int unsigned AW = $clog2(WINDOW_BYTES);       // store address
    localparam int unsigned CW = $clog2(WINDOW_BYTES + 1);   // counts up to the window
    localparam int unsigned IW = sbr_pkg::INDEX_W;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_CHECK, S_SLOT, S_WR, S_CRD, S_CCHK, S_FIN, S_RD, S_OUT, S_STAT
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]              r_clr_addr, n_clr_addr;
    logic [IW-1:0]              r_idx, n_idx;
    logic [sbr_pkg::BYTE_W-1:0] r_data, n_data;
    logic                       r_has, n_has;
    logic                       r_ends, n_ends;
    logic [sbr_pkg::ROOM_W-1:0] r_room, n_room;
    logic [IW-1:0]              r_released, n_released;
    logic [IW-1:0]              r_end_pos, n_end_pos;
    logic                       r_end_known, n_end_known;
    logic                       r_closed, n_closed;
    logic [CW-1:0]              r_waiting, n_waiting;
    logic [AW-1:0]              r_head, n_head;     // released mod window
    logic [AW-1:0]              r_off, n_off;       // byte offset from release point
    logic [AW-1:0]              r_slot, n_slot;
    logic [AW-1:0]              r_scan, n_scan;
    logic [CW-1:0]              r_cnt, n_cnt;       // length of in-order run
    logic [CW-1:0]              r_k, n_k;           // bytes released so far

    logic                       r_out_valid, n_out_valid;
    logic [sbr_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                       r_out_bvalid, n_out_bvalid;
    logic                       r_out_last, n_out_last;
    logic                       r_out_closed, n_out_closed;
    logic [sbr_pkg::COUNT_W-1:0] r_out_pend, n_out_pend;

    // store port
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_addr;
    sbr_pkg::t_entry            mem_wdata;
    sbr_pkg::t_entry            mem_rdata;

    // window test and slot arithmetic
    logic [IW-1:0]              diff, room_lim;
    logic                       hit;
    logic [AW:0]                slot_sum;
    logic [AW-1:0]              slot_wrap;
    logic                       out_free, run_last;

    sbr_store #(
        .DEPTH (WINDOW_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        slot_inc = (s == AW'(WINDOW_BYTES - 1)) ? '0 : s + AW'(1);
    endfunction

    always_comb begin
        diff     = r_idx - r_released;
        room_lim = (IW'(r_room) > IW'(WINDOW_BYTES)) ? IW'(WINDOW_BYTES) : IW'(r_room);
        hit      = r_has && (r_idx >= r_released) && (diff < room_lim);
        slot_sum = {1'b0, r_head} + {1'b0, r_off};
        slot_wrap = (slot_sum >= (AW+1)'(WINDOW_BYTES))
                  ? AW'(slot_sum - (AW+1)'(WINDOW_BYTES)) : slot_sum[AW-1:0];
        out_free = !r_out_valid || o_out.ready;
        run_last = (CW'(r_k + CW'(1)) == r_cnt);
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_idx        = r_idx;
        n_data       = r_data;
        n_has        = r_has;
        n_ends       = r_ends;
        n_room       = r_room;
        n_released  = r_released;
        n_end_pos    = r_end_pos;
        n_end_known  = r_end_known;
        n_closed     = r_closed;
        n_waiting    = r_waiting;
        n_head       = r_head;
        n_off        = r_off;
        n_slot       = r_slot;
        n_scan       = r_scan;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_bvalid = r_out_bvalid;
        n_out_last   = r_out_last;
        n_out_closed = r_out_closed;
        n_out_pend   = r_out_pend;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = r_head;
        mem_wdata    = '0;

        unique case (r_state)
            S_CLR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
                n_clr_addr = slot_inc(r_clr_addr);
                if (r_clr_addr == AW'(WINDOW_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_idx   = i_in.stream_index;
                    n_data  = i_in.data_byte;
                    n_has   = i_in.has_byte;
                    n_ends  = i_in.ends_stream;
                    n_room  = i_in.output_room;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_ends) begin
                    n_end_pos   = r_idx + IW'(r_has);
                    n_end_known = 1'b1;
                end
                n_off  = diff[AW-1:0];
                n_scan = r_head;
                n_cnt  = '0;
                n_state = hit ? S_SLOT : S_CRD;
            end
            S_SLOT: begin
                // fetch the old entry to learn whether the slot was already present
                mem_re   = 1'b1;
                mem_addr = slot_wrap;
                n_slot   = slot_wrap;
                n_state  = S_WR;
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_addr  = r_slot;
                mem_wdata = '{present: 1'b1, data: r_data};
                if (!mem_rdata.present) begin
                    n_waiting = r_waiting + CW'(1);
                end
                n_state = S_CRD;
            end
            S_CRD: begin
                mem_re   = 1'b1;
                mem_addr = r_scan;
                n_state  = S_CCHK;
            end
            S_CCHK: begin
                if (mem_rdata.present) begin
                    n_cnt  = CW'(r_cnt + CW'(1));
                    n_scan = slot_inc(r_scan);
                    n_state = (CW'(r_cnt + CW'(1)) == CW'(WINDOW_BYTES)) ? S_FIN : S_CRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_end_known && (r_released + IW'(r_cnt) == r_end_pos)) begin
                    n_closed = 1'b1;
                end
                n_waiting = r_waiting - r_cnt;
                n_k       = '0;
                n_state   = (r_cnt == '0) ? S_STAT : S_RD;
            end
            S_RD: begin
                mem_re   = 1'b1;
                mem_addr = r_head;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = mem_rdata.data;
                    n_out_bvalid = 1'b1;
                    n_out_last   = run_last;
                    n_out_closed = r_closed;
                    n_out_pend   = sbr_pkg::COUNT_W'(r_waiting);
                    mem_we       = 1'b1;
                    mem_addr     = r_head;
                    mem_wdata    = '0;
                    n_head       = slot_inc(r_head);
                    n_released   = r_released + IW'(1);
                    n_k          = CW'(r_k + CW'(1));
                    n_state      = run_last ? S_IDLE : S_RD;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = '0;
                    n_out_bvalid = 1'b0;
                    n_out_last   = 1'b1;
                    n_out_closed = r_closed;
                    n_out_pend   = sbr_pkg::COUNT_W'(r_waiting);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_released  <= '0;
            r_end_pos   <= '0;
            r_end_known <= 1'b0;
            r_closed    <= 1'b0;
            r_waiting   <= '0;
            r_head      <= '0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_released  <= n_released;
            r_end_pos   <= n_end_pos;
            r_end_known <= n_end_known;
            r_closed    <= n_closed;
            r_waiting   <= n_waiting;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_data       <= n_data;
        r_has        <= n_has;
        r_ends       <= n_ends;
        r_room       <= n_room;
        r_off        <= n_off;
        r_slot       <= n_slot;
        r_scan       <= n_scan;
        r_out_byte   <= n_out_byte;
        r_out_bvalid <= n_out_bvalid;
        r_out_last   <= n_out_last;
        r_out_closed <= n_out_closed;
        r_out_pend   <= n_out_pend;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.byte_valid    = r_out_bvalid;
    assign o_out.last_of_run   = r_out_last;
    assign o_out.stream_closed = r_out_closed;
    assign o_out.pending_count = r_out_pend;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for stream_byte_reassembler: shuffled segments, noise and stalls checked against a predictor.
module tb;

    localparam int SLOT_W       = 6;
    localparam int WIN          = 1 << SLOT_W;   // matches WINDOW_BYTES of the instance
    localparam int IDLE_PCT     = 24;
    localparam int HOLD_CYCLES  = 300;           // long receiver hold-off
    localparam int DRAIN_CYCLES = 300;           // longer than one worst-case item
    localparam int STIM_ITEMS   = 295;

    // One input item as the block sees it.
    typedef struct packed {
        logic [sbr_pkg::INDEX_W-1:0] stream_index;
        logic [sbr_pkg::BYTE_W-1:0]  data_byte;
        logic                        has_byte;
        logic                        ends_stream;
        logic [sbr_pkg::ROOM_W-1:0]  output_room;
    } t_seg_item;

    // One result item.
    typedef struct packed {
        logic [sbr_pkg::BYTE_W-1:0]  out_byte;
        logic                        byte_valid;
        logic                        last_of_run;
        logic                        stream_closed;
        logic [sbr_pkg::COUNT_W-1:0] pending_count;
    } t_rel_item;

    // Reassembly state: byte slots, present marks, release point and end tracking.
    typedef struct packed {
        logic [WIN-1:0][sbr_pkg::BYTE_W-1:0] slots;
        logic [WIN-1:0]                      present;
        logic [sbr_pkg::INDEX_W-1:0]         released;
        logic [sbr_pkg::INDEX_W-1:0]         end_at;
        logic                                end_known;
        logic                                closed;
        logic [sbr_pkg::COUNT_W-1:0]         waiting;
    } t_reasm_state;

    typedef enum {
        NZ_STATUS,     // no byte, no end flag
        NZ_BEYOND,     // byte past the room or the window
        NZ_STALE,      // byte already released
        NZ_OLD_END,    // end marker behind the release point
        NZ_WILD        // byte at a random 64-bit index
    } t_noise_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sbr_in_if  seg_if ();
    sbr_out_if rel_if ();

    stream_byte_reassembler #(
        .WINDOW_BYTES (WIN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (seg_if),
        .o_out   (rel_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_seg_item    segment_bytes[$];   // items waiting to be offered
    t_rel_item    release_due[$];     // results predicted, oldest first
    t_reasm_state plan_state   = '0;  // used while building stimulus
    t_reasm_state stream_state = '0;  // follows accepted items
    t_seg_item    seg_next;
    t_rel_item    rel_want;
    logic         seg_took = 1'b0;
    bit           rx_hold = 1'b0;
    int unsigned  total_items;
    int unsigned  items_offered = 0;
    int unsigned  items_taken = 0;
    int unsigned  results_seen = 0;
    int unsigned  fault_count = 0;

    // ------------------------------------------------------------------
    // Predictor: one item in, updated state out; with book set the
    // results go onto release_due.
    // ------------------------------------------------------------------
    function automatic t_reasm_state reassemble_step(input t_reasm_state st,
                                                     input t_seg_item it, input bit book);
        logic [sbr_pkg::BYTE_W-1:0]  run_bytes [WIN];
        logic [sbr_pkg::INDEX_W-1:0] room_eff;
        logic [SLOT_W-1:0]           slot;
        int                          n;
        t_rel_item                   r;

        // room wider than the window is clipped to the window
        room_eff = (it.output_room > sbr_pkg::ROOM_W'(WIN))
                 ? sbr_pkg::INDEX_W'(WIN) : sbr_pkg::INDEX_W'(it.output_room);

        // end position wraps at 2^64; recorded even when the byte is dropped
        if (it.ends_stream) begin
            st.end_at    = it.stream_index + sbr_pkg::INDEX_W'(it.has_byte);
            st.end_known = 1'b1;
        end

        // half-open window [released, released + room_eff)
        if (it.has_byte && it.stream_index >= st.released
                && it.stream_index - st.released < room_eff) begin
            slot = it.stream_index[SLOT_W-1:0];
            if (!st.present[slot]) begin
                st.present[slot] = 1'b1;
                st.waiting       = st.waiting + 1'b1;
            end
            st.slots[slot] = it.data_byte;
        end

        // release the contiguous run from the release point
        n = 0;
        slot = st.released[SLOT_W-1:0];
        while (n < WIN && st.present[slot]) begin
            run_bytes[n]     = st.slots[slot];
            st.present[slot] = 1'b0;
            st.waiting       = st.waiting - 1'b1;
            st.released      = st.released + 1'b1;
            n++;
            slot = st.released[SLOT_W-1:0];
        end

        if (st.end_known && st.released == st.end_at)
            st.closed = 1'b1;

        if (book) begin
            r.stream_closed = st.closed;
            r.pending_count = st.waiting;
            if (n == 0) begin
                r.out_byte    = '0;
                r.byte_valid  = 1'b0;
                r.last_of_run = 1'b1;
                release_due = {release_due, r};
            end else begin
                for (int k = 0; k < n; k++) begin
                    r.out_byte    = run_bytes[k];
                    r.byte_valid  = 1'b1;
                    r.last_of_run = (k == n - 1);
                    release_due = {release_due, r};
                end
            end
        end
        return st;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input int unsigned seq,
                               input logic [sbr_pkg::BYTE_W-1:0] got,
                               input logic [sbr_pkg::BYTE_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                    seq, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Stimulus building. plan_state tracks the release point so that
    // streams start where the block will be and noise lands where intended.
    // ------------------------------------------------------------------
    function automatic t_seg_item make_seg(input logic [sbr_pkg::INDEX_W-1:0] idx,
                                           input logic [sbr_pkg::BYTE_W-1:0] data,
                                           input logic has, input logic ends,
                                           input logic [sbr_pkg::ROOM_W-1:0] room);
        t_seg_item s;
        s.stream_index = idx;
        s.data_byte    = data;
        s.has_byte     = has;
        s.ends_stream  = ends;
        s.output_room  = room;
        return s;
    endfunction

    task automatic offer(input t_seg_item it);
        segment_bytes = {segment_bytes, it};
        plan_state = reassemble_step(plan_state, it, 1'b0);
    endtask

    task automatic offer_noise();
        t_noise_kind                 kind;
        logic [sbr_pkg::INDEX_W-1:0] rel;
        logic [sbr_pkg::INDEX_W-1:0] room_eff;
        logic [sbr_pkg::ROOM_W-1:0]  room;
        int                          span;

        kind = t_noise_kind'($urandom_range(0, 4));
        rel  = plan_state.released;
        room = sbr_pkg::ROOM_W'($urandom_range(0, 127));
        case (kind)
            NZ_BEYOND: begin
                room_eff = (room > sbr_pkg::ROOM_W'(WIN))
                         ? sbr_pkg::INDEX_W'(WIN) : sbr_pkg::INDEX_W'(room);
                offer(make_seg(rel + room_eff + $urandom_range(0, 40),
                               sbr_pkg::BYTE_W'($urandom), 1'b1, 1'b0, room));
            end
            NZ_STALE: begin
                if (rel > 0) begin
                    span = (rel > 51) ? 50 : int'(rel - 1);
                    offer(make_seg(rel - 1 - $urandom_range(0, span),
                                   sbr_pkg::BYTE_W'($urandom), 1'b1, 1'b0, room));
                end else begin
                    offer(make_seg(rel, sbr_pkg::BYTE_W'($urandom), 1'b0, 1'b0, room));
                end
            end
            NZ_OLD_END: begin
                // end lands behind the release point, so the stream stays open
                if (rel > 1) begin
                    span = (rel > 22) ? 20 : int'(rel - 2);
                    offer(make_seg(rel - 2 - $urandom_range(0, span),
                                   sbr_pkg::BYTE_W'($urandom),
                                   $urandom_range(0, 1) == 1, 1'b1, room));
                end else begin
                    offer(make_seg(rel, sbr_pkg::BYTE_W'($urandom), 1'b0, 1'b0, room));
                end
            end
            NZ_WILD:
                offer(make_seg({$urandom, $urandom}, sbr_pkg::BYTE_W'($urandom), 1'b1, 1'b0,
                               room));
            default:
                offer(make_seg({$urandom, $urandom}, sbr_pkg::BYTE_W'($urandom), 1'b0, 1'b0,
                               room));
        endcase
    endtask

    // A segment of len bytes from the release point, shuffled, with room
    // always wide enough to keep each byte; extra copies and noise mixed in.
    task automatic offer_stream(input int len, input bit close_it, input bit hold_first);
        logic [sbr_pkg::INDEX_W-1:0] pos [WIN];
        logic [sbr_pkg::INDEX_W-1:0] base;
        logic [sbr_pkg::INDEX_W-1:0] tmp;
        int                          j;
        int                          off;

        base = plan_state.released;
        for (int k = 0; k < len; k++)
            pos[k] = base + sbr_pkg::INDEX_W'(k);
        for (int k = len - 1; k > 0; k--) begin
            j      = $urandom_range(0, k);
            tmp    = pos[k];
            pos[k] = pos[j];
            pos[j] = tmp;
        end
        // oldest byte last: everything else piles up, then one long run
        if (hold_first) begin
            for (int k = 0; k < len; k++) begin
                if (pos[k] == base) begin
                    tmp          = pos[k];
                    pos[k]       = pos[len - 1];
                    pos[len - 1] = tmp;
                end
            end
        end
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                offer_noise();
            off = int'(pos[k] - base);
            offer(make_seg(pos[k], sbr_pkg::BYTE_W'($urandom), 1'b1,
                           close_it && pos[k] == base + sbr_pkg::INDEX_W'(len - 1),
                           sbr_pkg::ROOM_W'($urandom_range(127, off + 1))));
            if ($urandom_range(0, 7) == 0)
                offer(make_seg(pos[k], sbr_pkg::BYTE_W'($urandom), 1'b1, 1'b0,
                               sbr_pkg::ROOM_W'($urandom_range(0, 127))));
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: prediction at the accepting edge, driving at the falling edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        seg_took <= i_rst_n && seg_if.valid && seg_if.ready;
        if (i_rst_n && seg_if.valid && seg_if.ready) begin
            stream_state = reassemble_step(stream_state,
                                           make_seg(seg_if.stream_index, seg_if.data_byte,
                                                    seg_if.has_byte, seg_if.ends_stream,
                                                    seg_if.output_room),
                                           1'b1);
            items_taken++;
        end
    end

    // A held item stays until taken; a new one goes out unless this cycle idles.
    // Items 150..229 go out back to back.
    always @(negedge i_clk) begin
        if (i_rst_n && (!seg_if.valid || seg_took)) begin
            if (segment_bytes.size() != 0 && ((items_offered >= 150 && items_offered < 230)
                    || $urandom_range(0, 99) >= IDLE_PCT)) begin
                seg_next = segment_bytes[0];
                segment_bytes.delete(0);
                seg_if.stream_index <= seg_next.stream_index;
                seg_if.data_byte    <= seg_next.data_byte;
                seg_if.has_byte     <= seg_next.has_byte;
                seg_if.ends_stream  <= seg_next.ends_stream;
                seg_if.output_room  <= seg_next.output_room;
                seg_if.valid        <= 1'b1;
                items_offered++;
            end else begin
                seg_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, a calm stretch, and one long hold-off.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold)
            rel_if.ready <= 1'b0;
        else if (results_seen >= 180 && results_seen < 280)
            rel_if.ready <= 1'b1;
        else
            rel_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Hold-off while the sender keeps offering: the block fills and stalls its input.
    initial begin
        while (results_seen < 40)
            @(negedge i_clk);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rel_if.valid && rel_if.ready) begin
            if (release_due.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing expected (byte 0x%0h)",
                                        results_seen, rel_if.out_byte));
            end else begin
                rel_want = release_due[0];
                release_due.delete(0);
                check_field("out_byte", results_seen, rel_if.out_byte, rel_want.out_byte);
                check_field("byte_valid", results_seen, rel_if.byte_valid,
                            rel_want.byte_valid);
                check_field("last_of_run", results_seen, rel_if.last_of_run,
                            rel_want.last_of_run);
                check_field("stream_closed", results_seen, rel_if.stream_closed,
                            rel_want.stream_closed);
                check_field("pending_count", results_seen, rel_if.pending_count,
                            rel_want.pending_count);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        seg_if.valid        = 1'b0;
        seg_if.stream_index = '0;
        seg_if.data_byte    = '0;
        seg_if.has_byte     = 1'b0;
        seg_if.ends_stream  = 1'b0;
        seg_if.output_room  = '0;
        rel_if.ready        = 1'b0;

        // directed: window edges, room edges, overwrite, stale bytes, end markers
        offer(make_seg(64'd0, 8'h00, 1'b0, 1'b0, 7'd0));      // status only, idle block
        offer(make_seg(64'd1, 8'hFF, 1'b1, 1'b0, 7'd64));     // stored behind a gap
        offer(make_seg(64'd2, 8'h3C, 1'b1, 1'b0, 7'd2));      // one past the room: dropped
        offer(make_seg(64'd2, 8'h00, 1'b1, 1'b0, 7'd3));      // last slot of the room
        offer(make_seg(64'd2, 8'hA5, 1'b1, 1'b0, 7'd3));      // overwrites the waiting byte
        offer(make_seg(64'd0, 8'h11, 1'b1, 1'b0, 7'd0));      // zero room: dropped
        offer(make_seg(64'd64, 8'h22, 1'b1, 1'b0, 7'd127));   // room clipped, past window
        offer(make_seg(64'd63, 8'h33, 1'b1, 1'b0, 7'd127));   // last slot of the window
        offer(make_seg(64'd0, 8'h5A, 1'b1, 1'b0, 7'd1));      // fills the gap: run of three
        offer(make_seg(64'd1, 8'h44, 1'b1, 1'b0, 7'd64));     // already released
        offer(make_seg('1, 8'h80, 1'b1, 1'b1, 7'd127));       // end wraps to zero
        offer(make_seg(64'd2, 8'h00, 1'b0, 1'b1, 7'd0));      // end marker without a byte
        offer(make_seg(64'd66, 8'h7E, 1'b1, 1'b0, 7'd64));    // far edge of the window
        offer(make_seg(64'd3, 8'hC3, 1'b1, 1'b0, 7'd127));    // releases one byte

        // full window with the oldest byte last, then a random mix
        offer_stream(WIN, 1'b0, 1'b1);
        while (segment_bytes.size() < STIM_ITEMS) begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) offer_noise();
            else if ($urandom_range(0, 5) == 0)
                offer_stream($urandom_range(17, WIN), 1'b0, $urandom_range(0, 1) == 1);
            else
                offer_stream($urandom_range(1, 16), 1'b0, $urandom_range(0, 3) == 0);
        end

        // close the stream, then keep going after it is closed
        offer_stream($urandom_range(1, 16), 1'b1, 1'b0);
        if (!plan_state.closed)
            offer(make_seg(plan_state.released, sbr_pkg::BYTE_W'($urandom), 1'b0, 1'b1,
                           sbr_pkg::ROOM_W'($urandom_range(0, 127))));
        repeat (4) offer_noise();
        offer_stream($urandom_range(1, 16), 1'b0, 1'b0);
        total_items = segment_bytes.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < total_items || release_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fault_count == 0)
            $display("stream_byte_reassembler regression: pass");
        else
            $display("stream_byte_reassembler regression: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("stream_byte_reassembler regression: fail");
        $finish;
    end

endmodule
